// ===== rtl/element_vortex_metrics_macros.svh =====
// Assertion macros shared by the block's modules
`ifndef ELEMENT_VORTEX_METRICS_MACROS_SVH
`define ELEMENT_VORTEX_METRICS_MACROS_SVH

// Same-cycle implication, checked out of reset
`define EVM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define EVM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/evm_pkg.sv =====
package evm_pkg;

  typedef struct packed {
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] grad_x;
    logic signed [31:0] grad_y;
    logic signed [31:0] grad_z;
    logic               last_node;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] q_value;
    logic signed [31:0] vort_x;
    logic signed [31:0] vort_y;
    logic signed [31:0] vort_z;
    logic [30:0]        vort_magnitude;
  } out_item_t;

  // Queue entry: node item plus its classified dimension
  typedef struct packed {
    in_item_t item;
    logic     full_3d;
  } evm_qent_t;

  localparam logic [1:0] DIM_2D = 2'd2;
  localparam logic [1:0] DIM_RESET = 2'd3;
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned ACC_N = 9;

  function automatic logic signed [63:0] sat_add64(logic signed [63:0] a,
                                                   logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63])
      return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] sat_sub64(logic signed [63:0] a,
                                                   logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63])
      return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    return s[63:0];
  endfunction

  function automatic logic signed [31:0] clamp32(logic signed [63:0] x);
    if (x > 64'sd2147483647) return 32'sh7fffffff;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  // Tensor row and column of a flat entry index
  function automatic logic [1:0] row_of(logic [3:0] k);
    if (k < 4'd3) return 2'd0;
    if (k < 4'd6) return 2'd1;
    return 2'd2;
  endfunction

  function automatic logic [1:0] col_of(logic [3:0] k);
    if (k < 4'd3) return k[1:0];
    if (k < 4'd6) return 2'(k - 4'd3);
    return 2'(k - 4'd6);
  endfunction

endpackage

// ===== rtl/evm_front.sv =====
`include "element_vortex_metrics_macros.svh"

module evm_front
  import evm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [1:0] cfg_data,
  output logic      q_valid,
  output evm_qent_t q_data,
  input  logic      q_pop
);

  logic [1:0] dim_r, dim_nxt;
  evm_qent_t  mem_r [QDEPTH];
  logic       wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push;

  assign cfg_ready = 1'b1;
  assign in_ready  = (count_r != 2'(QDEPTH));
  assign push      = in_valid && in_ready;
  assign q_valid   = (count_r != 2'd0);
  assign q_data    = mem_r[rptr_r];

  // Update dimension and queue pointers
  always_comb begin
    dim_nxt   = (cfg_valid && cfg_ready) ? cfg_data : dim_r;
    wptr_nxt  = push ? ~wptr_r : wptr_r;
    rptr_nxt  = q_pop ? ~rptr_r : rptr_r;
    count_nxt = count_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r   <= DIM_RESET;
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      dim_r   <= dim_nxt;
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  // Classify and store the transfer
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r].item    <= in_data;
      mem_r[wptr_r].full_3d <= (dim_r != DIM_2D);
    end
  end

  `EVM_ASSERT_IMPL(a_cnt_bound, 1'b1, count_r <= 2'(QDEPTH), "queue overfilled")
  `EVM_ASSERT_NEXT(a_cnt_push, push && !q_pop, count_r == $past(count_r) + 2'd1, "push lost")

endmodule

// ===== rtl/evm_back.sv =====
`include "element_vortex_metrics_macros.svh"

module evm_back
  import evm_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  evm_qent_t q_data,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_AMUL = 10'b0000000010,
    S_AADD = 10'b0000000100,
    S_QMUL = 10'b0000001000,
    S_QADD = 10'b0000010000,
    S_VORT = 10'b0000100000,
    S_MMUL = 10'b0001000000,
    S_MADD = 10'b0010000000,
    S_SQRT = 10'b0100000000,
    S_DONE = 10'b1000000000
  } state_t;

  state_t             state_r, state_nxt;
  logic [4:0]         cnt_r, cnt_nxt;
  evm_qent_t          cur_r, cur_nxt;
  logic signed [63:0] acc_r [ACC_N];
  logic signed [63:0] acc_nxt [ACC_N];
  logic signed [63:0] prod_r, prod_nxt;
  logic signed [63:0] s_r, s_nxt;
  logic signed [31:0] vx_r, vx_nxt, vy_r, vy_nxt, vz_r, vz_nxt;
  logic [63:0]        msq_r, msq_nxt, n_r, n_nxt, rt_r, rt_nxt, bit_r, bit_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;
  logic [3:0]         k;
  logic               entry_used, qterm_used;
  logic [63:0]        trial;
  logic signed [63:0] q_wide;

  assign k         = cnt_r[3:0];
  assign mul_p     = mul_a * mul_b;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign trial     = rt_r + bit_r;
  assign q_wide    = (-s_r) >>> 1;

  // In 2D only the upper-left 2x2 block of the tensor is live
  assign entry_used = cur_r.full_3d || (row_of(k) != 2'd2 && col_of(k) != 2'd2);
  assign qterm_used = cur_r.full_3d || k == 4'd0 || k == 4'd1 || k == 4'd3;

  // Select shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    priority case (1'b1)
      state_r[1]: begin
        unique case (row_of(k))
          2'd0:    mul_a = cur_r.item.vel_x;
          2'd1:    mul_a = cur_r.item.vel_y;
          default: mul_a = cur_r.item.vel_z;
        endcase
        unique case (col_of(k))
          2'd0:    mul_b = cur_r.item.grad_x;
          2'd1:    mul_b = cur_r.item.grad_y;
          default: mul_b = cur_r.item.grad_z;
        endcase
      end
      state_r[3]: begin
        unique case (k)
          4'd0:    begin mul_a = clamp32(acc_r[0]); mul_b = clamp32(acc_r[0]); end
          4'd1:    begin mul_a = clamp32(acc_r[4]); mul_b = clamp32(acc_r[4]); end
          4'd2:    begin mul_a = clamp32(acc_r[8]); mul_b = clamp32(acc_r[8]); end
          4'd3:    begin mul_a = clamp32(acc_r[1]); mul_b = clamp32(acc_r[3]); end
          4'd4:    begin mul_a = clamp32(acc_r[2]); mul_b = clamp32(acc_r[6]); end
          default: begin mul_a = clamp32(acc_r[5]); mul_b = clamp32(acc_r[7]); end
        endcase
      end
      state_r[6]: begin
        unique case (k)
          4'd0:    begin mul_a = vx_r; mul_b = vx_r; end
          4'd1:    begin mul_a = vy_r; mul_b = vy_r; end
          default: begin mul_a = vz_r; mul_b = vz_r; end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Sequence accumulate, Q, vorticity, magnitude and result
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cur_nxt       = cur_r;
    acc_nxt       = acc_r;
    prod_nxt      = prod_r;
    s_nxt         = s_r;
    vx_nxt        = vx_r;
    vy_nxt        = vy_r;
    vz_nxt        = vz_r;
    msq_nxt       = msq_r;
    n_nxt         = n_r;
    rt_nxt        = rt_r;
    bit_nxt       = bit_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    q_pop         = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          cur_nxt   = q_data;
          cnt_nxt   = '0;
          state_nxt = S_AMUL;
        end
      end
      S_AMUL: begin
        prod_nxt  = mul_p;
        state_nxt = S_AADD;
      end
      S_AADD: begin
        if (entry_used)
          acc_nxt[k] = sat_add64(acc_r[k], prod_r >>> FRAC_BITS);
        if (k == 4'(ACC_N - 1)) begin
          cnt_nxt   = '0;
          s_nxt     = '0;
          state_nxt = cur_r.item.last_node ? S_QMUL : S_IDLE;
        end else begin
          cnt_nxt   = cnt_r + 5'd1;
          state_nxt = S_AMUL;
        end
      end
      S_QMUL: begin
        prod_nxt  = mul_p;
        state_nxt = S_QADD;
      end
      S_QADD: begin
        // Off-diagonal pairs count twice
        if (qterm_used)
          s_nxt = (k < 4'd3) ? s_r + (prod_r >>> FRAC_BITS)
                             : s_r + ((prod_r >>> FRAC_BITS) <<< 1);
        if (k == 4'd5) begin
          state_nxt = S_VORT;
        end else begin
          cnt_nxt   = cnt_r + 5'd1;
          state_nxt = S_QMUL;
        end
      end
      S_VORT: begin
        vz_nxt    = clamp32(sat_sub64(acc_r[3], acc_r[1]));
        vx_nxt    = cur_r.full_3d ? clamp32(sat_sub64(acc_r[7], acc_r[5])) : '0;
        vy_nxt    = cur_r.full_3d ? clamp32(sat_sub64(acc_r[2], acc_r[6])) : '0;
        msq_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = S_MMUL;
      end
      S_MMUL: begin
        prod_nxt  = mul_p;
        state_nxt = S_MADD;
      end
      S_MADD: begin
        msq_nxt = msq_r + 64'(prod_r);
        if (k == 4'd2) begin
          n_nxt     = msq_r + 64'(prod_r);
          rt_nxt    = '0;
          bit_nxt   = 64'd1 << 62;
          cnt_nxt   = '0;
          state_nxt = S_SQRT;
        end else begin
          cnt_nxt   = cnt_r + 5'd1;
          state_nxt = S_MMUL;
        end
      end
      S_SQRT: begin
        // One result bit per cycle
        if (n_r >= trial) begin
          n_nxt  = n_r - trial;
          rt_nxt = (rt_r >> 1) + bit_r;
        end else begin
          rt_nxt = rt_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd31)
          state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.q_value        = clamp32(q_wide);
          out_data_nxt.vort_x         = vx_r;
          out_data_nxt.vort_y         = vy_r;
          out_data_nxt.vort_z         = vz_r;
          out_data_nxt.vort_magnitude = (rt_r > 64'h7fffffff) ? 31'h7fffffff : rt_r[30:0];
          for (int i = 0; i < ACC_N; i++)
            acc_nxt[i] = '0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < ACC_N; i++)
        acc_r[i] <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      acc_r       <= acc_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    prod_r     <= prod_nxt;
    s_r        <= s_nxt;
    vx_r       <= vx_nxt;
    vy_r       <= vy_nxt;
    vz_r       <= vz_nxt;
    msq_r      <= msq_nxt;
    n_r        <= n_nxt;
    rt_r       <= rt_nxt;
    bit_r      <= bit_nxt;
    out_data_r <= out_data_nxt;
  end

  `EVM_ASSERT_IMPL(a_acc_idx, state_r == S_AADD, cnt_r < 5'(ACC_N), "entry index out of range")
  `EVM_ASSERT_NEXT(a_done_out, state_r == S_DONE && !out_valid_r, out_valid_r, "result dropped")

endmodule

// ===== rtl/element_vortex_metrics.sv =====
// Channel | Direction | Payload
// in_     | input     | in_item_t: node velocity, shape gradient, last-node flag
// out_    | output    | out_item_t: Q, vorticity x/y/z, vorticity magnitude
// cfg_    | input     | dimension (2 = 2D, other values 3D)
// A node takes nine multiply/accumulate pairs in the back end on one shared
// 32x32 multiplier. A last node adds the Q terms, the vorticity, the squared sum
// and a bit-serial square root, then loads the result.
// A two-entry queue in front accepts nodes while the back end works.
// Synchronous active-low reset clears the accumulator and sets 3D.
// A stalled result waits in the output register; the next result waits until it leaves.
module element_vortex_metrics
  import evm_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_data
);

  logic      q_valid, q_pop;
  evm_qent_t q_data;

  evm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop)
  );

  evm_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== test/tb_top.sv =====
module tb_top;
  import evm_pkg::*;

  localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] S64_MIN = {1'b1, 63'd0};
  localparam int QUIET_LIMIT = 8000;
  localparam int DRAIN_CYCLES = 120;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_data = DIM_RESET;

  element_vortex_metrics dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Shadow of the block: gradient tensor and dimension
  logic signed [63:0] grad_tensor [9];
  logic [1:0] shadow_dim;
  out_item_t expected_metrics [$];
  int errors = 0;
  int nodes_sent = 0;
  int elements_done = 0;
  int dims_seen = 0;
  bit stim_done = 0;

  function automatic logic signed [63:0] add_clip64(logic signed [63:0] a,
                                                    logic signed [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] clip32(logic signed [63:0] x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic logic [63:0] root_floor(logic [63:0] n);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Fold one node into the tensor; on the last node compute the metrics
  function automatic bit fold_node(in_item_t it, output out_item_t res);
    logic signed [63:0] v [3], g [3], gc [9], w [3];
    logic signed [63:0] s, q, t;
    logic [63:0] msq, mag;
    int nd;
    nd = (shadow_dim == DIM_2D) ? 2 : 3;
    v[0] = it.vel_x; v[1] = it.vel_y; v[2] = it.vel_z;
    g[0] = it.grad_x; g[1] = it.grad_y; g[2] = it.grad_z;
    res = '0;
    for (int i = 0; i < nd; i++)
      for (int j = 0; j < nd; j++)
        grad_tensor[i*3+j] = add_clip64(grad_tensor[i*3+j], (v[i] * g[j]) >>> 16);
    if (!it.last_node) return 0;
    for (int k = 0; k < 9; k++) gc[k] = clip32(grad_tensor[k]);
    s = 0;
    for (int i = 0; i < nd; i++)
      for (int j = 0; j < nd; j++)
        s = s + ((gc[i*3+j] * gc[j*3+i]) >>> 16);
    t = -s;
    q = clip32(t >>> 1);
    w[2] = clip32(add_clip64(grad_tensor[3], -grad_tensor[1]));
    if (nd == 3) begin
      // negating the 64-bit minimum cannot happen: entries stay far below it
      w[0] = clip32(add_clip64(grad_tensor[7], -grad_tensor[5]));
      w[1] = clip32(add_clip64(grad_tensor[2], -grad_tensor[6]));
    end else begin
      w[0] = 0;
      w[1] = 0;
    end
    msq = 0;
    for (int k = 0; k < 3; k++) msq = msq + 64'(w[k] * w[k]);
    mag = root_floor(msq);
    if (mag > 64'h7fffffff) mag = 64'h7fffffff;
    res.q_value = q[31:0];
    res.vort_x = w[0][31:0];
    res.vort_y = w[1][31:0];
    res.vort_z = w[2][31:0];
    res.vort_magnitude = mag[30:0];
    for (int k = 0; k < 9; k++) grad_tensor[k] = 0;
    return 1;
  endfunction

  // Transfer one node; the prediction is taken at acceptance
  task automatic push_node(in_item_t it, bit typed = 0, out_item_t want = '0);
    out_item_t res;
    int gap;
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    nodes_sent++;
    if (fold_node(it, res)) expected_metrics.push_back(typed ? want : res);
    gap = ($urandom_range(0, 3) == 0) ?
          (($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3)) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Write the dimension once the block has drained
  task automatic set_dimension(logic [1:0] d);
    in_valid <= 1'b0;
    while (expected_metrics.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    shadow_dim = d;
    dims_seen++;
  endtask

  function automatic logic [31:0] pick_word(int mode);
    case (mode)
      0: return 32'($signed($urandom_range(0, 32'h7ffff)) - 32'sh40000);
      1: return $urandom();
      default: begin
        case ($urandom_range(0, 4))
          0: return 32'h7fffffff;
          1: return 32'h80000000;
          2: return 32'h0;
          3: return 32'h00010000;
          default: return 32'hffffffff;
        endcase
      end
    endcase
  endfunction

  function automatic in_item_t random_node(bit last);
    in_item_t it;
    int mode;
    mode = ($urandom_range(0, 9) < 6) ? 0 : (($urandom_range(0, 2) == 0) ? 2 : 1);
    it.vel_x = pick_word(mode); it.vel_y = pick_word(mode); it.vel_z = pick_word(mode);
    it.grad_x = pick_word(mode); it.grad_y = pick_word(mode); it.grad_z = pick_word(mode);
    it.last_node = last;
    return it;
  endfunction

  function automatic in_item_t node_of(logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
                                       logic [31:0] gx, logic [31:0] gy, logic [31:0] gz,
                                       bit last);
    in_item_t it;
    it.vel_x = vx; it.vel_y = vy; it.vel_z = vz;
    it.grad_x = gx; it.grad_y = gy; it.grad_z = gz;
    it.last_node = last;
    return it;
  endfunction

  typedef struct {
    bit set_dim;
    logic [1:0] dim;
    in_item_t it;
    bit typed;
    out_item_t want;
  } step_row_t;

  step_row_t plan [$];

  function automatic out_item_t metrics_of(logic [31:0] q, logic [31:0] x, logic [31:0] y,
                                           logic [31:0] z, logic [30:0] m);
    out_item_t o;
    o.q_value = q; o.vort_x = x; o.vort_y = y; o.vort_z = z; o.vort_magnitude = m;
    return o;
  endfunction

  // Stimulus
  initial begin
    logic [31:0] mx, mn, one;
    int len;
    for (int k = 0; k < 9; k++) grad_tensor[k] = 0;
    shadow_dim = DIM_RESET;
    mx = 32'h7fffffff; mn = 32'h80000000; one = 32'h00010000;
    // directed: reset state, unit shear, extremes, 2D, mid-element dimension change
    plan.push_back('{0, 0, node_of(0, 0, 0, 0, 0, 0, 1), 1, '0});
    plan.push_back('{0, 0, node_of(one, 0, 0, 0, one, 0, 1), 1,
                     metrics_of(0, 0, 0, 32'hffff0000, 31'h10000)});
    plan.push_back('{0, 0, node_of(mx, mx, mx, mx, mx, mx, 0), 0, '0});
    plan.push_back('{0, 0, node_of(mn, mn, mn, mn, mn, mn, 1), 0, '0});
    plan.push_back('{0, 0, node_of(mn, mn, mn, mn, mn, mn, 1), 0, '0});
    plan.push_back('{0, 0, node_of(mx, mn, mx, mn, mx, mn, 1), 0, '0});
    plan.push_back('{0, 0, node_of(mn, mx, 0, mx, mn, one, 1), 0, '0});
    plan.push_back('{0, 0, node_of(32'hffffffff, 1, mx, 1, 32'hffffffff, mn, 1), 0, '0});
    plan.push_back('{1, DIM_2D, node_of(one, 0, mx, 0, one, mx, 1), 1,
                     metrics_of(0, 0, 0, 32'hffff0000, 31'h10000)});
    plan.push_back('{0, 0, node_of(mx, mn, mx, mx, mx, mn, 1), 0, '0});
    plan.push_back('{0, 0, node_of(mn, mx, mn, mx, mn, mx, 1), 0, '0});
    plan.push_back('{1, 2'd0, node_of(one, 2*one, 3*one, -one, one, one, 0), 0, '0});
    plan.push_back('{1, DIM_2D, node_of(mx, one, mn, one, mn, mx, 0), 0, '0});
    plan.push_back('{1, 2'd1, node_of(one, mx, one, mn, one, mx, 1), 0, '0});
    plan.push_back('{0, 0, node_of(mx, 0, 0, 0, 0, mx, 1), 0, '0});
    plan.push_back('{0, 0, node_of(0, 0, mx, mx, 0, 0, 1), 0, '0});
    plan.push_back('{1, DIM_RESET, node_of(mx, mx, mx, mx, mx, mx, 1), 0, '0});

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (plan[r]) begin
      if (plan[r].set_dim) set_dimension(plan[r].dim);
      push_node(plan[r].it, plan[r].typed, plan[r].want);
    end

    // random elements, one dimension setting per phase
    for (int ph = 0; ph < 5; ph++) begin
      set_dimension(ph == 4 ? 2'($urandom_range(0, 3)) :
                    (ph == 1 ? DIM_2D : 2'(ph == 0 ? 3 : ph - 2)));
      for (int n = 0; n < 300; ) begin
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 27) : $urandom_range(1, 6);
        for (int k = 0; k < len; k++)
          push_node(random_node(k == len - 1 || $urandom_range(0, 49) == 0));
        n += len;
      end
    end
    in_valid <= 1'b0;
    while (expected_metrics.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    stim_done = 1;
  end

  // Result side: random stalls, one long hold-off, compare per field
  initial begin
    out_item_t exp;
    int hold;
    bit held_long;
    hold = 0;
    held_long = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (expected_metrics.size() == 0) begin
          $display("%0t: unexpected result %h", $realtime, out_data);
          errors++;
        end else begin
          exp = expected_metrics.pop_front();
          elements_done++;
          if (out_data.q_value !== exp.q_value) begin
            $display("%0t: q_value exp %h got %h", $realtime, exp.q_value, out_data.q_value);
            errors++;
          end
          if (out_data.vort_x !== exp.vort_x) begin
            $display("%0t: vort_x exp %h got %h", $realtime, exp.vort_x, out_data.vort_x);
            errors++;
          end
          if (out_data.vort_y !== exp.vort_y) begin
            $display("%0t: vort_y exp %h got %h", $realtime, exp.vort_y, out_data.vort_y);
            errors++;
          end
          if (out_data.vort_z !== exp.vort_z) begin
            $display("%0t: vort_z exp %h got %h", $realtime, exp.vort_z, out_data.vort_z);
            errors++;
          end
          if (out_data.vort_magnitude !== exp.vort_magnitude) begin
            $display("%0t: vort_magnitude exp %h got %h", $realtime,
                     exp.vort_magnitude, out_data.vort_magnitude);
            errors++;
          end
        end
      end
      // pick the next ready level
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if (!held_long && elements_done == 40) begin
        held_long = 1;
        hold = 600;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        hold = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 3);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog on quiet cycles, then final verdict
  initial begin
    int quiet;
    quiet = 0;
    while (!stim_done && quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    if (!stim_done) begin
      $display("timeout after %0d quiet cycles", quiet);
      $display("FAILURE");
      $finish;
    end else begin
      $display("covered %0d nodes, %0d element results, %0d dimension writes",
               nodes_sent, elements_done, dims_seen);
      if (errors == 0 && expected_metrics.size() == 0) begin
        $display("SUCCESS");
      end else begin
        $display("%0d mismatches, %0d results missing", errors, expected_metrics.size());
        $display("FAILURE");
      end
      $finish;
    end
  end

endmodule
